[rtl/length_prefixed_frame_deframer_core_defines.svh]
// Assertion macros for the deframer.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_CORE_DEFINES_SVH
`ifndef SYNTH
`define LPFD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lpfd assertion failed");
`define LPFD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpfd assertion failed");
`define LPFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpfd assertion failed");
`else
`define LPFD_ASSERT(label, clk, rst, prop)
`define LPFD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LPFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/lpfd_pkg.sv]
package lpfd_pkg;

   localparam int HEADER_BYTES = 8;
   localparam int HDR_W        = HEADER_BYTES * 8;
   localparam int FILL_W       = $clog2(HEADER_BYTES);

   localparam logic [15:0] SYNC_WORD_RESET   = 16'hFFD5;
   localparam int          QUEUE_DEPTH_DFLT  = 4;

   // input op codes
   localparam logic OP_DATA    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_BADSYNC = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] channel;
      logic [15:0] sequence_res;
      logic [15:0] frame_length;
      logic [7:0]  payload_byte;
      logic        last_of_frame;
   } lpfd_item_type;

   typedef struct packed {
      logic          valid;
      lpfd_item_type item;
   } lpfd_xfer_type;

endpackage

[rtl/lpfd_req_if.sv]
interface lpfd_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;
   logic       chunk_end;

   modport source (output valid, op, rx_byte, chunk_end, input ready);
   modport sink   (input valid, op, rx_byte, chunk_end, output ready);
endinterface

[rtl/lpfd_rsp_if.sv]
interface lpfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] channel;
   logic [15:0] sequence_res;
   logic [15:0] frame_length;
   logic [7:0]  payload_byte;
   logic        last_of_frame;

   modport source (output valid, kind, channel, sequence_res, frame_length,
                   payload_byte, last_of_frame, input ready);
   modport sink   (input valid, kind, channel, sequence_res, frame_length,
                   payload_byte, last_of_frame, output ready);
endinterface

[rtl/length_prefixed_frame_deframer_core.sv]
// A result item is registered in the result queue and then in the output register before it appears on rsp_ch.
// Throughput: one byte per cycle; req_ch.ready drops only when the result queue
// (QUEUE_DEPTH items) is full because the consumer stalls rsp_ch.
// Reset (synchronous, active high): parser back to header collection, queue
// emptied, output invalid, sync word register back to 0xFFD5.
module length_prefixed_frame_deframer_core
   import lpfd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DFLT
) (
   input  logic        clock,
   input  logic        reset,
   lpfd_req_if.sink    req_ch,
   lpfd_rsp_if.source  rsp_ch,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   // Expected sync word; the user must write it only while the block is idle (not enforced here).
   logic [15:0] sync_word_ff, sync_word_in;

   // Front -> queue -> back. The queue decouples the parser, which takes a byte
   // per cycle while the queue is not full, from a consumer that may stall at any time.
   lpfd_xfer_type push;
   lpfd_xfer_type head;
   logic          queue_full;
   logic          pop;

   assign sync_word_in = csr_write_enable ? csr_write_data : sync_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff <= SYNC_WORD_RESET;
      end else begin
         sync_word_ff <= sync_word_in;
      end
   end

   // Front: header shift register, fill counter, payload countdown and the
   // header / payload / drop mode. Classifies each byte and pushes at most
   // one result item into the queue.
   lpfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .sync_word  (sync_word_ff),
      .queue_full (queue_full),
      .push       (push),
      .req_ch     (req_ch)
   );

   // Short result queue; a full queue is the only thing that stalls input.
   lpfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   // Back: output register; blanks frame tags on bad-sync items and refills
   // in the same cycle the consumer takes the current item.
   lpfd_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

[rtl/lpfd_front.sv]
module lpfd_front
   import lpfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [15:0]   sync_word,
   input  logic          queue_full,
   output lpfd_xfer_type push,
   lpfd_req_if.sink      req_ch
);

   localparam logic [1:0] MODE_HEADER  = 2'd0;
   localparam logic [1:0] MODE_PAYLOAD = 2'd1;
   localparam logic [1:0] MODE_DROP    = 2'd2;
   localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(HEADER_BYTES - 1);

   logic [1:0]        mode_ff, mode_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [15:0]       left_ff, left_in;
   logic [HDR_W-1:0]  hdr_ff, hdr_in;
   logic [HDR_W-1:0]  hdr_shift;
   logic              accept;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign hdr_shift    = {hdr_ff[HDR_W-9:0], req_ch.rx_byte};

   always_comb begin
      mode_in    = mode_ff;
      fill_in    = fill_ff;
      left_in    = left_ff;
      hdr_in     = hdr_ff;
      push.valid = 1'b0;
      push.item.kind          = KIND_PAYLOAD;
      push.item.sequence_res  = hdr_ff[47:32];
      push.item.channel       = hdr_ff[31:16];
      push.item.frame_length  = hdr_ff[15:0];
      push.item.payload_byte  = 8'd0;
      push.item.last_of_frame = 1'b0;
      if (accept) begin
         if (req_ch.op == OP_RESTART) begin
            mode_in = MODE_HEADER;
            fill_in = '0;
            left_in = 16'd0;
         end else begin
            case (mode_ff)
               MODE_DROP: begin
                  if (req_ch.chunk_end) begin
                     mode_in = MODE_HEADER;
                  end
               end
               MODE_PAYLOAD: begin
                  left_in                 = left_ff - 16'd1;
                  push.valid              = 1'b1;
                  push.item.payload_byte  = req_ch.rx_byte;
                  push.item.last_of_frame = (left_in == 16'd0);
                  if (left_in == 16'd0) begin
                     mode_in = MODE_HEADER;
                  end
               end
               default: begin
                  // collecting header; unused code lands here too
                  mode_in = MODE_HEADER;
                  hdr_in  = hdr_shift;
                  if (fill_ff == FILL_LAST) begin
                     fill_in    = '0;
                     push.item.sequence_res = hdr_shift[47:32];
                     push.item.channel      = hdr_shift[31:16];
                     push.item.frame_length = hdr_shift[15:0];
                     if (hdr_shift[63:48] != sync_word) begin
                        push.valid     = 1'b1;
                        push.item.kind = KIND_BADSYNC;
                        mode_in = req_ch.chunk_end ? MODE_HEADER : MODE_DROP;
                     end else begin
                        left_in = hdr_shift[15:0];
                        if (hdr_shift[15:0] == 16'd0) begin
                           push.valid              = 1'b1;
                           push.item.kind          = KIND_EMPTY;
                           push.item.last_of_frame = 1'b1;
                        end else begin
                           mode_in = MODE_PAYLOAD;
                        end
                     end
                  end else begin
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HEADER;
         fill_ff <= '0;
         left_ff <= 16'd0;
      end else begin
         mode_ff <= mode_in;
         fill_ff <= fill_in;
         left_ff <= left_in;
      end
      hdr_ff <= hdr_in;
   end

endmodule

[rtl/lpfd_queue.sv]
`include "length_prefixed_frame_deframer_core_defines.svh"
module lpfd_queue
   import lpfd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DFLT
) (
   input  logic          clock,
   input  logic          reset,
   input  lpfd_xfer_type push,
   input  logic          pop,
   output logic          full,
   output lpfd_xfer_type head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   lpfd_item_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push.valid) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.item;
      end
   end

   `LPFD_ASSERT(a_count_range, clock, reset, count_ff <= CNT_FULL)
   `LPFD_ASSERT_IMPL(a_no_overflow, clock, reset, full, !push.valid)
   `LPFD_ASSERT_NEXT(a_count_track, clock, reset, 1'b1, count_ff == $past(count_in))
   `LPFD_ASSERT_IMPL(a_ptr_gap, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff)

endmodule

[rtl/lpfd_back.sv]
module lpfd_back
   import lpfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lpfd_xfer_type head,
   output logic          pop,
   lpfd_rsp_if.source    rsp_ch
);

   logic          valid_ff, valid_in;
   lpfd_item_type item_ff, item_in;
   logic          load;

   assign load = head.valid && (!valid_ff || rsp_ch.ready);
   assign pop  = load;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = head.item;
         // bad sync carries no frame tags
         if (head.item.kind == KIND_BADSYNC) begin
            item_in.channel      = 16'd0;
            item_in.sequence_res = 16'd0;
            item_in.frame_length = 16'd0;
         end
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.kind          = item_ff.kind;
   assign rsp_ch.channel       = item_ff.channel;
   assign rsp_ch.sequence_res  = item_ff.sequence_res;
   assign rsp_ch.frame_length  = item_ff.frame_length;
   assign rsp_ch.payload_byte  = item_ff.payload_byte;
   assign rsp_ch.last_of_frame = item_ff.last_of_frame;

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

// Deframer testbench: byte stream in on req_ch, tagged payload / empty-frame /
// bad-sync items out on rsp_ch. Every accepted input item goes through a
// software copy of the parser, and the result items it produces are queued in
// order. Every item taken from rsp_ch is checked against the head of that queue.
module tb;
   import lpfd_pkg::*;

   localparam int          RESET_CYCLES = 11;
   localparam int          DRAIN_CYCLES = 8;      // settling time after the last owed result
   localparam int          HOLD_CYCLES  = 300;    // long consumer stall
   localparam int unsigned PHASE_ITEMS  = 375;    // four sync settings, ~1500 items
   localparam int unsigned CYCLE_LIMIT  = 500000;

   typedef enum logic [1:0] {
      PARSE_HEADER  = 2'd0,
      PARSE_PAYLOAD = 2'd1,
      PARSE_DROP    = 2'd2
   } parse_mode_type;

   // Parser copy plus the queue of result items it still owes.
   class deframe_scoreboard;
      logic [15:0]    sync_word_reg;
      parse_mode_type mode;
      logic [7:0]     header_bytes [HEADER_BYTES];
      int unsigned    header_fill;
      logic [15:0]    bytes_left;
      lpfd_item_type  owed_results [$];
      int unsigned    mismatches;
      int unsigned    results_seen;
      int unsigned    kind_count [3];

      function new();
         sync_word_reg = SYNC_WORD_RESET;
         mode          = PARSE_HEADER;
         header_fill   = 0;
         bytes_left    = '0;
         mismatches    = 0;
         results_seen  = 0;
         foreach (header_bytes[i]) header_bytes[i] = '0;
         foreach (kind_count[i]) kind_count[i] = 0;
      endfunction

      function void set_sync(logic [15:0] value);
         sync_word_reg = value;
      endfunction

      function int unsigned owed_count();
         return owed_results.size();
      endfunction

      function logic [15:0] header_word(int unsigned at);
         return {header_bytes[at], header_bytes[at + 1]};
      endfunction

      // Payload and empty-frame items carry the frame's header fields.
      function lpfd_item_type framed_result(logic [1:0] kind, logic [7:0] data,
                                            logic last);
         lpfd_item_type r;
         r.kind          = kind;
         r.sequence_res  = header_word(2);
         r.channel       = header_word(4);
         r.frame_length  = header_word(6);
         r.payload_byte  = data;
         r.last_of_frame = last;
         return r;
      endfunction

      function void note_input(logic op, logic [7:0] data, logic chunk_last);
         lpfd_item_type r;
         r = '0;
         if (op == OP_RESTART) begin
            mode        = PARSE_HEADER;
            header_fill = 0;
            bytes_left  = '0;
            return;
         end
         case (mode)
            PARSE_DROP: begin
               // byte carrying the chunk end is dropped too
               if (chunk_last) mode = PARSE_HEADER;
            end
            PARSE_PAYLOAD: begin
               bytes_left = bytes_left - 16'd1;
               if (bytes_left == 16'd0) mode = PARSE_HEADER;
               owed_results.push_back(framed_result(KIND_PAYLOAD, data,
                                                    bytes_left == 16'd0));
            end
            default: begin
               header_bytes[header_fill] = data;
               header_fill++;
               if (header_fill == HEADER_BYTES) begin
                  header_fill = 0;
                  if (header_word(0) != sync_word_reg) begin
                     // no drop needed when the bad header closes the chunk
                     mode   = chunk_last ? PARSE_HEADER : PARSE_DROP;
                     r.kind = KIND_BADSYNC;
                     owed_results.push_back(r);
                  end else begin
                     bytes_left = header_word(6);
                     if (bytes_left == 16'd0)
                        owed_results.push_back(framed_result(KIND_EMPTY, 8'h00, 1'b1));
                     else
                        mode = PARSE_PAYLOAD;
                  end
               end
            end
         endcase
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(lpfd_item_type got);
         lpfd_item_type want;
         results_seen++;
         if (owed_results.size() == 0) begin
            $error("result item with nothing expected: kind %0d", got.kind);
            mismatches++;
            return;
         end
         want = owed_results.pop_front();
         if (want.kind < 3) kind_count[want.kind]++;
         compare_field("kind", 16'(want.kind), 16'(got.kind));
         compare_field("channel", want.channel, got.channel);
         compare_field("sequence_res", want.sequence_res, got.sequence_res);
         compare_field("frame_length", want.frame_length, got.frame_length);
         compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
         compare_field("last_of_frame", 16'(want.last_of_frame),
                       16'(got.last_of_frame));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;

   lpfd_req_if req_ch ();
   lpfd_rsp_if rsp_ch ();

   deframe_scoreboard board = new();

   int unsigned items_sent    = 0;
   int unsigned sync_settings = 1;     // reset value counts as the first
   int unsigned cycle_count   = 0;
   bit          send_calm     = 1'b0;

   length_prefixed_frame_deframer_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // Hard stop in case the handshake hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, board.owed_count());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Idle cycles before an item; calm stretches have none.
   function automatic int unsigned draw_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   // Occasional chunk end where it should not matter.
   function automatic logic rare_bit();
      return ($urandom_range(0, 15) == 0);
   endfunction

   // One item on req_ch. Called at a rising edge; returns at the accepting edge.
   // valid is lowered only when a gap follows, so it never toggles in one step.
   task automatic send_item(input logic op, input logic [7:0] data,
                            input logic chunk_last);
      int unsigned gap;
      if (items_sent % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.op        <= op;
      req_ch.rx_byte   <= data;
      req_ch.chunk_end <= chunk_last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_input(op, data, chunk_last);
      items_sent++;
   endtask

   task automatic send_restart();
      send_item(OP_RESTART, 8'($urandom), 1'($urandom_range(0, 1)));
   endtask

   // Big-endian header: sync, sequence, channel, length.
   task automatic send_header(input logic [15:0] sync, input logic [15:0] seq_no,
                              input logic [15:0] chan, input logic [15:0] len,
                              input logic last_ce);
      logic [63:0] hdr;
      hdr = {sync, seq_no, chan, len};
      for (int i = 0; i < HEADER_BYTES; i++)
         send_item(OP_DATA, hdr[63 - 8 * i -: 8],
                   (i == HEADER_BYTES - 1) ? last_ce : rare_bit());
   endtask

   task automatic send_bytes(input int unsigned count, input bit spread_chunk_ends);
      for (int unsigned i = 0; i < count; i++)
         send_item(OP_DATA, 8'($urandom), spread_chunk_ends ? rare_bit() : 1'b0);
   endtask

   // Mostly well-formed frames; the rest bad sync, cut-off frames and junk.
   task automatic random_frame();
      int unsigned pick, n;
      logic [15:0] seq_no, chan, len, word;
      logic        ce;
      pick   = $urandom_range(0, 99);
      seq_no = 16'($urandom);
      chan   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
      word   = board.sync_word_reg;
      n      = $urandom_range(0, 19);
      len    = (n < 14) ? 16'($urandom_range(0, 4)) :
               (n < 19) ? 16'($urandom_range(5, 24)) : 16'($urandom_range(25, 60));
      if (pick < 70) begin
         send_header(word, seq_no, chan, len, rare_bit());
         send_bytes(32'(len), 1'b1);
      end else if (pick < 80) begin
         // bad sync; unless the header closed the chunk, junk is dropped
         // up to and including the chunk-end byte
         word = word ^ 16'($urandom_range(1, 65535));
         ce   = 1'($urandom_range(0, 1));
         send_header(word, seq_no, chan, len, ce);
         if (!ce) begin
            send_bytes($urandom_range(0, 5), 1'b0);
            send_item(OP_DATA, 8'($urandom), 1'b1);
         end
      end else if (pick < 90) begin
         // any length, cut short by a restart
         len = 16'($urandom);
         send_header(word, seq_no, chan, len, rare_bit());
         n = (len == 16'd0) ? 0 : $urandom_range(0, (len > 16'd7) ? 6 : 32'(len) - 1);
         send_bytes(n, 1'b1);
         send_restart();
      end else begin
         // partial header or junk, then restart (sometimes a lone restart)
         send_bytes($urandom_range(0, 7), 1'b1);
         send_restart();
      end
   endtask

   // Leave the block idle with nothing owed, then load a new sync word.
   task automatic settle_and_write_sync(input logic [15:0] value);
      send_restart();
      req_ch.valid <= 1'b0;
      while (board.owed_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.set_sync(value);
      sync_settings++;
   endtask

   // Consumer: random stalls, calm stretches, and one long hold so the
   // internal queue fills and req_ch.ready drops.
   initial begin : result_sink
      lpfd_item_type got;
      int unsigned   stall;
      bit            calm;
      bit            held;
      calm = 1'b0;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (board.results_seen % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         stall = draw_wait(calm);
         if (!held && board.results_seen >= 150) begin
            held  = 1'b1;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         got = {rsp_ch.kind, rsp_ch.channel, rsp_ch.sequence_res,
                rsp_ch.frame_length, rsp_ch.payload_byte, rsp_ch.last_of_frame};
         board.check_result(got);
      end
   end

   initial begin : stimulus
      logic [15:0] phase_sync [4];
      req_ch.valid     <= 1'b0;
      req_ch.op        <= OP_DATA;
      req_ch.rx_byte   <= 8'h00;
      req_ch.chunk_end <= 1'b0;
      rsp_ch.ready     <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 16'h0000;
      phase_sync = '{SYNC_WORD_RESET, 16'h0000, 16'hFFFF, 16'($urandom)};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed, with the reset sync word:
      // restart in the middle of a header (its byte and chunk end ignored)
      send_item(OP_DATA, 8'hFF, 1'b0);
      send_item(OP_DATA, 8'hD5, 1'b0);
      send_item(OP_RESTART, 8'hFF, 1'b1);
      // empty frame, all-ones sequence and channel
      send_header(SYNC_WORD_RESET, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
      // bad sync on the chunk's last byte: next byte starts a new header
      send_header(16'hFFD4, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      // one-byte frame, chunk end inside the payload has no effect
      send_header(SYNC_WORD_RESET, 16'h0000, 16'h0002, 16'h0001, 1'b0);
      send_item(OP_DATA, 8'hFF, 1'b1);

      // Random frames under four sync words: reset value, both extremes, random.
      for (int p = 0; p < 4; p++) begin
         if (p > 0) settle_and_write_sync(phase_sync[p]);
         while (items_sent < PHASE_ITEMS * (p + 1)) random_frame();
      end

      req_ch.valid <= 1'b0;
      while (board.owed_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("deframer: %0d items in, %0d results out, %0d sync words",
               items_sent, board.results_seen, sync_settings);
      $display("   %0d payload bytes, %0d empty frames, %0d bad sync headers",
               board.kind_count[KIND_PAYLOAD], board.kind_count[KIND_EMPTY],
               board.kind_count[KIND_BADSYNC]);
      if (board.mismatches == 0 && board.owed_count() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

[sim.f]
+incdir+rtl
rtl/lpfd_pkg.sv
rtl/lpfd_req_if.sv
rtl/lpfd_rsp_if.sv
rtl/lpfd_front.sv
rtl/lpfd_queue.sv
rtl/lpfd_back.sv
rtl/length_prefixed_frame_deframer_core.sv
test/tb.sv
